[sv/frustum_box_classify_macros.svh]
// Assertion macros for the frustum box classifier.
// Depends on nothing; included by the top level, which supplies clk and rst_n.
`ifndef FRUSTUM_BOX_CLASSIFY_MACROS_SVH
`define FRUSTUM_BOX_CLASSIFY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum box classifier: check failed");
`define FBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum box classifier: check failed");
`else
`define FBC_ASSERT_IMPL(label, ante, cons)
`define FBC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/fbc_pkg.sv]
// Shared types and constants of the frustum box classifier.
// Depends on nothing; used by every module of the block.
package fbc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_SEL_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [3:0] PLANE_LIMIT = 4'(NUM_PLANES);

  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_TEST = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CLASS_OUTSIDE   = 2'd0,
    CLASS_INTERSECT = 2'd1,
    CLASS_INSIDE    = 2'd2
  } box_class_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] offset;
  } plane_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } box_t;

  typedef struct packed {
    logic                   en;
    logic [PLANE_SEL_W-1:0] idx;
    plane_t                 plane;
  } plane_wr_t;

  // Per-plane verdict: pos_behind means the positive vertex is strictly
  // behind the plane, neg_behind the same for the negative vertex.
  typedef struct packed {
    logic pos_behind;
    logic neg_behind;
  } lane_flags_t;

endpackage

[sv/fbc_plane_store.sv]
// Register file that holds the frustum planes, one entry per plane.
// Depends on fbc_pkg.
module fbc_plane_store (
  input  logic              clk,
  input  fbc_pkg::plane_wr_t wr,
  output fbc_pkg::plane_t   planes_r [fbc_pkg::NUM_PLANES]
);
  import fbc_pkg::*;

  // Contents are undefined until written, so there is no reset.
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (wr.en && (wr.idx == PLANE_SEL_W'(p))) begin
        planes_r[p] <= wr.plane;
      end
    end
  end

endmodule

[sv/fbc_plane_lane.sv]
// One plane lane: vertex selection and exact products, then the wide sum
// and its sign for both the positive and the negative vertex. Depends on fbc_pkg.
module fbc_plane_lane (
  input  logic                 clk,
  input  fbc_pkg::plane_t      plane,
  input  fbc_pkg::box_t        box,
  output fbc_pkg::lane_flags_t flags_r
);
  import fbc_pkg::*;

  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] neg_x, neg_y, neg_z;
  logic signed [63:0] pos_prod_nxt [3];
  logic signed [63:0] neg_prod_nxt [3];
  logic signed [63:0] pos_prod_r [3];
  logic signed [63:0] neg_prod_r [3];
  logic signed [31:0] dist_r;
  logic signed [65:0] dist_term;
  logic signed [65:0] pos_sum;
  logic signed [65:0] neg_sum;
  lane_flags_t        flags_nxt;

  // A zero normal component counts as non-negative.
  always_comb begin
    pos_x = plane.nx[31] ? box.min_x : box.max_x;
    neg_x = plane.nx[31] ? box.max_x : box.min_x;
    pos_y = plane.ny[31] ? box.min_y : box.max_y;
    neg_y = plane.ny[31] ? box.max_y : box.min_y;
    pos_z = plane.nz[31] ? box.min_z : box.max_z;
    neg_z = plane.nz[31] ? box.max_z : box.min_z;
    pos_prod_nxt[0] = 64'(plane.nx) * 64'(pos_x);
    pos_prod_nxt[1] = 64'(plane.ny) * 64'(pos_y);
    pos_prod_nxt[2] = 64'(plane.nz) * 64'(pos_z);
    neg_prod_nxt[0] = 64'(plane.nx) * 64'(neg_x);
    neg_prod_nxt[1] = 64'(plane.ny) * 64'(neg_y);
    neg_prod_nxt[2] = 64'(plane.nz) * 64'(neg_z);
  end

  always_ff @(posedge clk) begin
    pos_prod_r <= pos_prod_nxt;
    neg_prod_r <= neg_prod_nxt;
    dist_r     <= plane.offset;
  end

  // Products are Q32.32, so the distance is aligned by a shift of 16.
  always_comb begin
    dist_term = 66'(dist_r) <<< 16;
    pos_sum = 66'(pos_prod_r[0]) + 66'(pos_prod_r[1]) + 66'(pos_prod_r[2]) + dist_term;
    neg_sum = 66'(neg_prod_r[0]) + 66'(neg_prod_r[1]) + 66'(neg_prod_r[2]) + dist_term;
    flags_nxt.pos_behind = pos_sum[65];
    flags_nxt.neg_behind = neg_sum[65];
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
  end

endmodule

[sv/frustum_box_classify.sv]
// Top level of the frustum box classifier: request register, plane store,
// plane lanes and the final classification. Depends on fbc_pkg, fbc_plane_store,
// fbc_plane_lane and frustum_box_classify_macros.svh.

// The block classifies axis-aligned boxes against a set of frustum planes and
// accepts one request in every clock cycle; busy is always low, because the
// result side cannot stall and nothing inside ever waits. A load request
// (in_mode 0) writes one plane into the plane store and gives no result; a
// load with a plane index beyond the last plane is dropped. A test request
// (in_mode 1) gives exactly one result, shown on out_box_class and out_visible
// for the single cycle in which out_strobe is high, after the request passes
// through the request register, the lanes' product registers, the lanes' sign
// registers and the output register. Every plane has its own lane with six 32
// by 32 multipliers, which is what sustains the rate of one box per cycle. A
// load takes effect for every test accepted after it, including one accepted
// in the very next cycle; tests already accepted still see the older planes.
// Every plane has to be loaded before the first test, since the store is not
// cleared by reset. The class is outside when any plane has its positive
// vertex strictly behind it, inside when every negative vertex is on or in
// front of its plane, and intersecting otherwise; out_visible is high unless
// the class is outside.
module frustum_box_classify (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [2:0]  in_plane_index,
  input  logic signed [31:0] in_plane_nx,
  input  logic signed [31:0] in_plane_ny,
  input  logic signed [31:0] in_plane_nz,
  input  logic signed [31:0] in_plane_dist,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic signed [31:0] in_box_max_z,
  output logic        out_strobe,
  output logic [1:0]  out_box_class,
  output logic        out_visible
);
  import fbc_pkg::*;

  `include "frustum_box_classify_macros.svh"

  logic        accept;
  plane_wr_t   store_wr;
  plane_t      planes [NUM_PLANES];
  lane_flags_t lane_flags [NUM_PLANES];

  logic        s1_valid_r, s1_valid_nxt;
  box_t        s1_box_r;
  logic        s2_valid_r;
  logic        s3_valid_r;

  logic        any_outside;
  logic        all_inside;
  box_class_t  class_nxt;
  logic        out_strobe_r;
  box_class_t  out_class_r;
  logic        out_visible_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Loads go straight into the store on the edge that accepts them.
  always_comb begin
    store_wr.en    = accept && (in_mode == MODE_LOAD) &&
                     ({1'b0, in_plane_index} < PLANE_LIMIT);
    store_wr.idx   = in_plane_index[PLANE_SEL_W-1:0];
    store_wr.plane = '{nx: in_plane_nx, ny: in_plane_ny, nz: in_plane_nz,
                       offset: in_plane_dist};
  end

  fbc_plane_store u_store (
    .clk      (clk),
    .wr       (store_wr),
    .planes_r (planes)
  );

  assign s1_valid_nxt = accept && (in_mode == MODE_TEST);

  // Request register: only tests travel down the pipeline.
  always_ff @(posedge clk) begin
    s1_box_r <= '{min_x: in_box_min_x, min_y: in_box_min_y, min_z: in_box_min_z,
                  max_x: in_box_max_x, max_y: in_box_max_y, max_z: in_box_max_z};
  end

  // Valid bits follow the request register and the two lane stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fbc_plane_lane u_lane (
      .clk     (clk),
      .plane   (planes[p]),
      .box     (s1_box_r),
      .flags_r (lane_flags[p])
    );
  end

  // Outside on any plane wins; inside needs every plane to agree.
  always_comb begin
    any_outside = 1'b0;
    all_inside  = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      any_outside = any_outside | lane_flags[p].pos_behind;
      all_inside  = all_inside & ~lane_flags[p].neg_behind;
    end
    if (any_outside) begin
      class_nxt = CLASS_OUTSIDE;
    end else if (all_inside) begin
      class_nxt = CLASS_INSIDE;
    end else begin
      class_nxt = CLASS_INTERSECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_class_r   <= class_nxt;
    out_visible_r <= ~any_outside;
  end

  assign out_strobe    = out_strobe_r;
  assign out_box_class = out_class_r;
  assign out_visible   = out_visible_r;

  // A result appears only for an accepted test.
  `FBC_ASSERT_IMPL(a_result_has_test, out_strobe, $past(start && !busy && in_mode, 4))
  // A test accepted with no reset since then always yields its result.
  `FBC_ASSERT_IMPL(a_test_gives_result, $past(start && in_mode && rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1), out_strobe)
  // The visible flag and the class come from separate registers; they must agree.
  `FBC_ASSERT_IMPL(a_visible_matches, out_strobe, out_visible == (out_box_class != CLASS_OUTSIDE))

endmodule
